/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DLPG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dlpg assertion failed");

// Checks that a condition implies another in the same cycle.
`define DLPG_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   `DLPG_ASSERT(label, clk, rst, (cond) |-> (expr))

// Checks that a condition implies another in the next cycle.
`define DLPG_ASSERT_NEXT(label, clk, rst, cond, expr) \
   `DLPG_ASSERT(label, clk, rst, (cond) |=> (expr))

`endif

/* rtl/core/dlpg_pkg.sv */
// Package with the fixed widths, the pitch reset value and the command codes of the line rasterizer.
package dlpg_pkg;

   localparam int ADDR_W      = 26;
   localparam int WORD_W      = 32;
   localparam int PITCH_W     = 13;
   localparam int COORD_W     = 16;
   localparam int CHAN_W      = 8;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

endpackage

/* rtl/core/dda_line_pixel_generator.sv */
// Top level of the DDA line rasterizer with its step sequencer and output register.
// A start item of a line with pixels gives its result once the bit-serial slope divider is done;
// the sequencer waits in ST_DIV until then.
// A step of an active line passes through accept, multiply and address sum before its result.
// Any other item has its result in the cycle after its accept; the next waits until it leaves.
// Synchronous active-high reset clears the sequencer, active flag and rsp_valid; pitch is 640.
module dda_line_pixel_generator
   import dlpg_pkg::*;
#(
   parameter int COORD_INT_BITS  = 12,
   parameter int COORD_FRAC_BITS = 4,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [PITCH_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [COORD_W-1:0] req_first_x,
   input  logic [COORD_W-1:0] req_first_y,
   input  logic [COORD_W-1:0] req_second_x,
   input  logic [COORD_W-1:0] req_second_y,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_blue,
   input  logic [CHAN_W-1:0]  req_alpha,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_write_valid,
   output logic [ADDR_W-1:0]  rsp_pixel_address,
   output logic [WORD_W-1:0]  rsp_pixel_word,
   output logic               rsp_last_pixel,
   output logic               rsp_line_active
);

   localparam int W     = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int CI    = COORD_INT_BITS;
   localparam int QB    = SLOPE_FRAC_BITS + 1;
   localparam int SW    = SLOPE_FRAC_BITS + 2;
   localparam int AW    = COORD_INT_BITS + SLOPE_FRAC_BITS + 3;
   localparam int MW    = AW - SLOPE_FRAC_BITS;
   localparam int AO    = ADDR_W - 2;
   localparam int SHIFT = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
   localparam logic [W:0]    HALF    = (W + 1)'((1 << COORD_FRAC_BITS) >> 1);
   localparam logic [CI-1:0] PIX_MAX = {CI{1'b1}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_SUM  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [PITCH_W-1:0]   pitch_ff;
   logic                 active_ff, active_in;
   logic                 x_is_major_ff, x_is_major_in;
   logic                 step_down_ff, step_down_in;
   logic                 slope_neg_ff, slope_neg_in;
   logic [CI-1:0]        major_current_ff, major_current_in;
   logic [CI-1:0]        major_stop_ff, major_stop_in;
   logic signed [SW-1:0] slope_ff, slope_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0]    colour_ff, colour_in;
   logic [AO-1:0]        prod_ff, prod_in;
   logic [AO-1:0]        px_ff, px_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_write_valid_ff, rsp_write_valid_in;
   logic [ADDR_W-1:0]    rsp_pixel_address_ff, rsp_pixel_address_in;
   logic [WORD_W-1:0]    rsp_pixel_word_ff, rsp_pixel_word_in;
   logic                 rsp_last_pixel_ff, rsp_last_pixel_in;
   logic                 rsp_line_active_ff, rsp_line_active_in;

   logic [W-1:0]         x1, y1, x2, y2;
   logic signed [W:0]    dx, dy;
   logic [W-1:0]         adx, ady, amaj, amin;
   logic                 xmaj, dmaj_neg, dmin_neg;
   logic [W-1:0]         maj1, maj2, origin;
   logic [W:0]           rnd1, rnd2;
   logic [CI-1:0]        ms, me;
   logic                 new_active;

   logic                 div_start, div_done;
   logic [QB-1:0]        quotient;
   logic [SW-1:0]        quo_ext;

   logic [AW-1:0]        acc_mag;
   logic [MW-1:0]        mag_shift;
   logic signed [MW-1:0] minor;
   logic [AO-1:0]        minor_ext, major_ext, py;
   logic signed [AW-1:0] slope_ext;
   logic [CI-1:0]        major_next;
   logic                 accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   assign x1 = W'(req_first_x);
   assign y1 = W'(req_first_y);
   assign x2 = W'(req_second_x);
   assign y2 = W'(req_second_y);
   assign dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
   assign dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
   assign adx = dx[W] ? W'(-dx) : W'(dx);
   assign ady = dy[W] ? W'(-dy) : W'(dy);
   assign xmaj     = adx >= ady;
   assign amaj     = xmaj ? adx : ady;
   assign amin     = xmaj ? ady : adx;
   assign dmaj_neg = xmaj ? dx[W] : dy[W];
   assign dmin_neg = xmaj ? dy[W] : dx[W];
   assign maj1     = xmaj ? x1 : y1;
   assign maj2     = xmaj ? x2 : y2;
   assign origin   = xmaj ? y1 : x1;
   assign rnd1 = ({1'b0, maj1} + HALF) >> COORD_FRAC_BITS;
   assign rnd2 = ({1'b0, maj2} + HALF) >> COORD_FRAC_BITS;
   assign ms = (rnd1 > (W + 1)'(PIX_MAX)) ? PIX_MAX : rnd1[CI-1:0];
   assign me = (rnd2 > (W + 1)'(PIX_MAX)) ? PIX_MAX : rnd2[CI-1:0];
   assign new_active = (amaj != '0) && (dmaj_neg ? (ms > me) : (ms < me));

   assign div_start = accept && (req_cmd == CMD_START) && new_active;

   dlpg_divider #(
      .WIDTH    (W),
      .QUO_BITS (QB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (amin),
      .divisor  (amaj),
      .quotient (quotient),
      .done     (div_done)
   );

   assign quo_ext   = {1'b0, quotient};
   assign acc_mag   = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign mag_shift = MW'(acc_mag >> SLOPE_FRAC_BITS);
   assign minor     = acc_ff[AW-1] ? -$signed(mag_shift) : $signed(mag_shift);
   assign minor_ext = AO'(minor);
   assign major_ext = AO'(major_current_ff);
   assign py        = x_is_major_ff ? minor_ext : major_ext;
   assign slope_ext = AW'(slope_ff);
   assign major_next = step_down_ff ? (major_current_ff - 1'b1) : (major_current_ff + 1'b1);

   always_comb begin
      state_in             = state_ff;
      active_in            = active_ff;
      x_is_major_in        = x_is_major_ff;
      step_down_in         = step_down_ff;
      slope_neg_in         = slope_neg_ff;
      major_current_in     = major_current_ff;
      major_stop_in        = major_stop_ff;
      slope_in             = slope_ff;
      acc_in               = acc_ff;
      colour_in            = colour_ff;
      prod_in              = prod_ff;
      px_in                = px_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_write_valid_in   = rsp_write_valid_ff;
      rsp_pixel_address_in = rsp_pixel_address_ff;
      rsp_pixel_word_in    = rsp_pixel_word_ff;
      rsp_last_pixel_in    = rsp_last_pixel_ff;
      rsp_line_active_in   = rsp_line_active_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_START) begin
                  x_is_major_in    = xmaj;
                  step_down_in     = dmaj_neg;
                  slope_neg_in     = dmin_neg != dmaj_neg;
                  major_current_in = ms;
                  major_stop_in    = me;
                  acc_in           = AW'({1'b0, origin}) <<< SHIFT;
                  colour_in        = {req_alpha, req_red, req_green, req_blue};
                  active_in        = new_active;
                  if (new_active) begin
                     state_in = ST_DIV;
                  end else begin
                     rsp_valid_in         = 1'b1;
                     rsp_write_valid_in   = 1'b0;
                     rsp_pixel_address_in = '0;
                     rsp_pixel_word_in    = '0;
                     rsp_last_pixel_in    = 1'b0;
                     rsp_line_active_in   = 1'b0;
                  end
               end else if (active_ff) begin
                  prod_in            = AO'(py * AO'(pitch_ff));
                  px_in              = x_is_major_ff ? major_ext : minor_ext;
                  acc_in             = step_down_ff ? (acc_ff - slope_ext) : (acc_ff + slope_ext);
                  major_current_in   = major_next;
                  active_in          = major_next != major_stop_ff;
                  rsp_write_valid_in = 1'b1;
                  rsp_pixel_word_in  = colour_ff;
                  rsp_last_pixel_in  = major_next == major_stop_ff;
                  rsp_line_active_in = major_next != major_stop_ff;
                  state_in           = ST_MUL;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_write_valid_in   = 1'b0;
                  rsp_pixel_address_in = '0;
                  rsp_pixel_word_in    = '0;
                  rsp_last_pixel_in    = 1'b0;
                  rsp_line_active_in   = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in             = slope_neg_ff ? -$signed(quo_ext) : $signed(quo_ext);
               rsp_valid_in         = 1'b1;
               rsp_write_valid_in   = 1'b0;
               rsp_pixel_address_in = '0;
               rsp_pixel_word_in    = '0;
               rsp_last_pixel_in    = 1'b0;
               rsp_line_active_in   = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rsp_pixel_address_in = {AO'(prod_ff + px_ff), 2'b00};
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_is_major_ff        <= x_is_major_in;
      step_down_ff         <= step_down_in;
      slope_neg_ff         <= slope_neg_in;
      major_current_ff     <= major_current_in;
      major_stop_ff        <= major_stop_in;
      slope_ff             <= slope_in;
      acc_ff               <= acc_in;
      colour_ff            <= colour_in;
      prod_ff              <= prod_in;
      px_ff                <= px_in;
      rsp_write_valid_ff   <= rsp_write_valid_in;
      rsp_pixel_address_ff <= rsp_pixel_address_in;
      rsp_pixel_word_ff    <= rsp_pixel_word_in;
      rsp_last_pixel_ff    <= rsp_last_pixel_in;
      rsp_line_active_ff   <= rsp_line_active_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pitch_ff     <= PITCH_RESET;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            pitch_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_write_valid_ff;
   assign rsp_pixel_address = rsp_pixel_address_ff;
   assign rsp_pixel_word    = rsp_pixel_word_ff;
   assign rsp_last_pixel    = rsp_last_pixel_ff;
   assign rsp_line_active   = rsp_line_active_ff;

endmodule

/* rtl/core/dlpg_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module dlpg_divider #(
   parameter int WIDTH    = 16,
   parameter int QUO_BITS = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDTH-1:0]    dividend,
   input  logic [WIDTH-1:0]    divisor,
   output logic [QUO_BITS-1:0] quotient,
   output logic                done
);

   localparam int CNT_W = $clog2(QUO_BITS + 1);

   logic [WIDTH:0]      rem_ff, rem_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0]    div_ff, div_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                ge;
   logic [WIDTH:0]      trial;

   assign ge    = rem_ff >= {1'b0, div_ff};
   assign trial = ge ? (rem_ff - {1'b0, div_ff}) : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         quo_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(QUO_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {trial[WIDTH-1:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/core/dlpg_checker.sv */
// Port-level checker for the line rasterizer and its bind to the top level.
`include "assert_macros.svh"

module dlpg_checker
   import dlpg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_write_valid,
   input logic [ADDR_W-1:0] rsp_pixel_address,
   input logic [WORD_W-1:0] rsp_pixel_word,
   input logic              rsp_last_pixel,
   input logic              rsp_line_active
);

   `DLPG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `DLPG_ASSERT_IMPLY(a_last_ends_line, clock, reset, rsp_valid && rsp_last_pixel,
                      rsp_write_valid && !rsp_line_active)
   `DLPG_ASSERT_IMPLY(a_no_write_no_data, clock, reset, rsp_valid && !rsp_write_valid,
                      rsp_pixel_word == '0 && rsp_pixel_address == '0)
   `DLPG_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_pixel_address))

endmodule

bind dda_line_pixel_generator dlpg_checker u_dlpg_checker (.*);

/* sim/tb_dda_line_pixel_generator.sv */
// Self-checking testbench that predicts every pixel item of the line rasterizer and compares it.
`timescale 1ns / 1ps

typedef struct {
   logic                              cmd;
   logic [dlpg_pkg::COORD_W-1:0]      first_x;
   logic [dlpg_pkg::COORD_W-1:0]      first_y;
   logic [dlpg_pkg::COORD_W-1:0]      second_x;
   logic [dlpg_pkg::COORD_W-1:0]      second_y;
   logic [dlpg_pkg::CHAN_W-1:0]       red;
   logic [dlpg_pkg::CHAN_W-1:0]       green;
   logic [dlpg_pkg::CHAN_W-1:0]       blue;
   logic [dlpg_pkg::CHAN_W-1:0]       alpha;
} line_item_type;

typedef struct packed {
   logic                              write_valid;
   logic [dlpg_pkg::ADDR_W-1:0]       pixel_address;
   logic [dlpg_pkg::WORD_W-1:0]       pixel_word;
   logic                              last_pixel;
   logic                              line_active;
} pixel_result_type;

class raster_scoreboard_type;
   localparam int COORD_INT  = 12;
   localparam int COORD_FRAC = 4;
   localparam int SLOPE_FRAC = 16;
   localparam int HALF_LSB   = (1 << COORD_FRAC) >> 1;
   localparam int PIX_MAX    = (1 << COORD_INT) - 1;

   bit                            line_live;
   bit                            x_major;
   bit                            walk_down;
   bit [COORD_INT-1:0]            major_first;
   bit [COORD_INT-1:0]            major_now;
   bit [COORD_INT-1:0]            major_last;
   bit [dlpg_pkg::COORD_W-1:0]    minor_start;
   longint                        slope;
   bit [dlpg_pkg::WORD_W-1:0]     colour;
   bit [dlpg_pkg::PITCH_W-1:0]    pitch;
   pixel_result_type              expected_pixels[$];
   int unsigned                   mismatches;
   int unsigned                   lines_started;
   int unsigned                   pixels_written;
   int unsigned                   idle_steps;

   function new();
      line_live   = 1'b0;
      x_major     = 1'b0;
      walk_down   = 1'b0;
      major_first = '0;
      major_now   = '0;
      major_last  = '0;
      minor_start = '0;
      slope       = 0;
      colour      = '0;
      pitch       = dlpg_pkg::PITCH_RESET;
      mismatches  = 0;
      lines_started  = 0;
      pixels_written = 0;
      idle_steps     = 0;
   endfunction

   function bit [COORD_INT-1:0] to_pixel(bit [dlpg_pkg::COORD_W-1:0] c);
      int unsigned p;
      p = (int'(c) + HALF_LSB) >> COORD_FRAC;
      if (p > PIX_MAX) begin
         p = PIX_MAX;
      end
      return p[COORD_INT-1:0];
   endfunction

   function void accept_item(line_item_type item);
      longint        dx;
      longint        dy;
      longint        adx;
      longint        ady;
      longint        amaj;
      longint        amin;
      longint        q;
      longint        k;
      longint        acc;
      longint        minor;
      longint        px;
      longint        py;
      bit [63:0]     byte_off;
      bit            neg_maj;
      bit            neg_min;
      pixel_result_type res;
      res = '0;
      if (item.cmd == dlpg_pkg::CMD_START) begin
         lines_started++;
         colour = {item.alpha, item.red, item.green, item.blue};
         dx = longint'(item.second_x) - longint'(item.first_x);
         dy = longint'(item.second_y) - longint'(item.first_y);
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         x_major = (adx >= ady);
         if (x_major) begin
            neg_maj = (dx < 0);
            neg_min = (dy < 0);
            amaj = adx;
            amin = ady;
            major_first = to_pixel(item.first_x);
            major_last  = to_pixel(item.second_x);
            minor_start = item.first_y;
         end else begin
            neg_maj = (dy < 0);
            neg_min = (dx < 0);
            amaj = ady;
            amin = adx;
            major_first = to_pixel(item.first_y);
            major_last  = to_pixel(item.second_y);
            minor_start = item.first_x;
         end
         major_now = major_first;
         walk_down = neg_maj;
         if (amaj == 0) begin
            slope = 0;
            line_live = 1'b0;
         end else begin
            q = (amin << SLOPE_FRAC) / amaj;
            slope = (neg_min != neg_maj) ? -q : q;
            line_live = walk_down ? (major_first > major_last) : (major_first < major_last);
         end
         res.line_active = line_live;
      end else if (line_live) begin
         pixels_written++;
         k = longint'(major_now) - longint'(major_first);
         acc = longint'(minor_start) * (longint'(1) << (SLOPE_FRAC - COORD_FRAC)) + slope * k;
         minor = (acc < 0) ? -((-acc) >> SLOPE_FRAC) : (acc >> SLOPE_FRAC);
         px = x_major ? longint'(major_now) : minor;
         py = x_major ? minor : longint'(major_now);
         byte_off = (py * longint'(pitch) + px) * 4;
         res.write_valid   = 1'b1;
         res.pixel_address = byte_off[dlpg_pkg::ADDR_W-1:0];
         res.pixel_word    = colour;
         major_now = walk_down ? major_now - 1'b1 : major_now + 1'b1;
         if (major_now == major_last) begin
            res.last_pixel = 1'b1;
            line_live = 1'b0;
         end
         res.line_active = line_live;
      end else begin
         idle_steps++;
      end
      expected_pixels.push_back(res);
   endfunction

   task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
   endtask

   task check_pixel(pixel_result_type got);
      pixel_result_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("unexpected item", '0, 64'(got.pixel_address));
      end else begin
         want = expected_pixels.pop_front();
         if (got.write_valid !== want.write_valid) begin
            report_mismatch("write_valid", 64'(want.write_valid), 64'(got.write_valid));
         end
         if (got.pixel_address !== want.pixel_address) begin
            report_mismatch("pixel_address", 64'(want.pixel_address), 64'(got.pixel_address));
         end
         if (got.pixel_word !== want.pixel_word) begin
            report_mismatch("pixel_word", 64'(want.pixel_word), 64'(got.pixel_word));
         end
         if (got.last_pixel !== want.last_pixel) begin
            report_mismatch("last_pixel", 64'(want.last_pixel), 64'(got.last_pixel));
         end
         if (got.line_active !== want.line_active) begin
            report_mismatch("line_active", 64'(want.line_active), 64'(got.line_active));
         end
      end
   endtask
endclass

module tb_dda_line_pixel_generator;
   import dlpg_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_ITEMS   = 70;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [PITCH_W-1:0] csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = CMD_STEP;
   logic [COORD_W-1:0] req_first_x = '0;
   logic [COORD_W-1:0] req_first_y = '0;
   logic [COORD_W-1:0] req_second_x = '0;
   logic [COORD_W-1:0] req_second_y = '0;
   logic [CHAN_W-1:0]  req_red = '0;
   logic [CHAN_W-1:0]  req_green = '0;
   logic [CHAN_W-1:0]  req_blue = '0;
   logic [CHAN_W-1:0]  req_alpha = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_write_valid;
   logic [ADDR_W-1:0]  rsp_pixel_address;
   logic [WORD_W-1:0]  rsp_pixel_word;
   logic               rsp_last_pixel;
   logic               rsp_line_active;

   bit                    idle_on = 1'b1;
   bit                    hold_request = 1'b0;
   int unsigned           items_sent = 0;
   raster_scoreboard_type raster = new();

   dda_line_pixel_generator uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_word    (rsp_pixel_word),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_line_active   (rsp_line_active)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic line_item_type random_item(logic cmd);
      line_item_type it;
      it.cmd      = cmd;
      it.first_x  = COORD_W'($urandom);
      it.first_y  = COORD_W'($urandom);
      it.second_x = COORD_W'($urandom);
      it.second_y = COORD_W'($urandom);
      it.red      = CHAN_W'($urandom);
      it.green    = CHAN_W'($urandom);
      it.blue     = CHAN_W'($urandom);
      it.alpha    = CHAN_W'($urandom);
      return it;
   endfunction

   task automatic send_item(line_item_type item);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd      = item.cmd;
      req_first_x  = item.first_x;
      req_first_y  = item.first_y;
      req_second_x = item.second_x;
      req_second_y = item.second_y;
      req_red      = item.red;
      req_green    = item.green;
      req_blue     = item.blue;
      req_alpha    = item.alpha;
      req_valid    = 1'b1;
      do @(posedge clock); while (req_stall);
      raster.accept_item(item);
      items_sent++;
   endtask

   task automatic send_steps(int unsigned count);
      repeat (count) send_item(random_item(CMD_STEP));
   endtask

   task automatic send_start(logic [15:0] fx, logic [15:0] fy, logic [15:0] sx,
                             logic [15:0] sy, logic [31:0] argb);
      line_item_type it;
      it = '{CMD_START, fx, fy, sx, sy, argb[23:16], argb[15:8], argb[7:0], argb[31:24]};
      send_item(it);
   endtask

   task automatic send_random_line(int unsigned max_px);
      line_item_type it;
      int          major_d;
      int          minor_d;
      int          first_major;
      int          first_minor;
      int          last_major;
      int          last_minor;
      int unsigned steps;
      bit          x_axis;
      major_d = $urandom_range(0, max_px * 16 + 15);
      minor_d = $urandom_range(0, major_d);
      first_major = $urandom_range(0, 16'hFFFF);
      first_minor = $urandom_range(0, 16'hFFFF);
      last_major = $urandom_range(0, 1) ? first_major + major_d : first_major - major_d;
      if (last_major > 16'hFFFF || last_major < 0) begin
         last_major = 2 * first_major - last_major;
      end
      last_minor = $urandom_range(0, 1) ? first_minor + minor_d : first_minor - minor_d;
      if (last_minor > 16'hFFFF || last_minor < 0) begin
         last_minor = 2 * first_minor - last_minor;
      end
      x_axis = $urandom_range(0, 1);
      it = random_item(CMD_START);
      it.first_x  = x_axis ? COORD_W'(first_major) : COORD_W'(first_minor);
      it.first_y  = x_axis ? COORD_W'(first_minor) : COORD_W'(first_major);
      it.second_x = x_axis ? COORD_W'(last_major) : COORD_W'(last_minor);
      it.second_y = x_axis ? COORD_W'(last_minor) : COORD_W'(last_major);
      send_item(it);
      steps = (major_d >> 4) + $urandom_range(0, 2);
      if ($urandom_range(99) < 15) begin
         steps = $urandom_range(0, steps);
      end
      send_steps(steps);
   endtask

   task automatic run_phase(int unsigned budget);
      int unsigned mark;
      int unsigned pick;
      mark = items_sent;
      while (items_sent - mark < budget) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_random_line(12);
         end else if (pick < 78) begin
            send_random_line(60);
         end else if (pick < 92) begin
            send_item(random_item(CMD_START));
            send_steps($urandom_range(0, 4));
         end else begin
            send_steps(1);
         end
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (raster.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pitch(logic [PITCH_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(posedge clock);
      raster.pitch = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin : result_sink
      int unsigned      hold_left;
      pixel_result_type got;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = idle_on && ($urandom_range(99) < 34);
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.write_valid   = rsp_write_valid;
            got.pixel_address = rsp_pixel_address;
            got.pixel_word    = rsp_pixel_word;
            got.last_pixel    = rsp_last_pixel;
            got.line_active   = rsp_line_active;
            raster.check_pixel(got);
         end
      end
   end

   initial begin : stimulus
      logic [PITCH_W-1:0] pitch_plan[5];
      pitch_plan[0] = 13'd1;
      pitch_plan[1] = 13'd4096;
      pitch_plan[2] = PITCH_W'($urandom_range(2, 4095));
      pitch_plan[3] = PITCH_W'($urandom_range(2, 4095));
      pitch_plan[4] = 13'd640;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A step before any line, then a short ascending x-major line with one extra step.
      send_steps(1);
      send_start(16'h0010, 16'h0020, 16'h0050, 16'h0030, 32'h0000_0000);
      send_steps(5);
      // A descending y-major line with a negative slope, abandoned by a restart.
      send_start(16'h0060, 16'h0090, 16'h0080, 16'h0018, 32'h1234_5678);
      send_steps(2);
      // Identical endpoints, then endpoints that round to the same pixel.
      send_start(16'h0100, 16'h0100, 16'h0100, 16'h0100, 32'hFFFF_FFFF);
      send_steps(1);
      send_start(16'h0010, 16'h0040, 16'h0017, 16'h0041, 32'hA5A5_5A5A);
      send_steps(1);
      // Coordinates at the top of the range saturate when rounded.
      send_start(16'hFFFF, 16'hFFFF, 16'hFFC0, 16'hFFF0, 32'h8001_FF7E);
      send_steps(3);
      // A diagonal line breaks the tie toward x; then a minor axis that runs toward zero.
      send_start(16'h0000, 16'h0000, 16'h0030, 16'h0030, 32'h00FF_00FF);
      send_steps(2);
      send_start(16'h0007, 16'h0001, 16'h0028, 16'h0000, 32'hFF00_FF00);
      send_steps(2);

      for (int p = 0; p < 5; p++) begin
         settle();
         write_pitch(pitch_plan[p]);
         idle_on = (p != 2);
         if (p == 3) begin
            @(posedge clock);
            hold_request = 1'b1;
            send_start(16'h0000, 16'h0100, 16'h0400, 16'h0180, $urandom);
            send_steps(64);
         end
         run_phase(PHASE_ITEMS);
      end
      idle_on = 1'b1;
      settle();

      $display("Sent %0d items: %0d line starts, %0d pixel writes and %0d steps with no line.",
               items_sent, raster.lines_started, raster.pixels_written, raster.idle_steps);
      $display("Pitches 640, 1, 4096 and random widths ran, with one long output hold-off.");
      if (raster.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dlpg_pkg.sv
rtl/core/dlpg_divider.sv
rtl/core/dda_line_pixel_generator.sv
rtl/core/dlpg_checker.sv
sim/tb_dda_line_pixel_generator.sv
